>>> hw/rtl/zrt_pkg.sv
// Shared constants and types for the zigzag rail transposer.
package zrt_pkg;

  // Fixed field widths.
  localparam int CHAR_W = 8;
  localparam int ROWS_W = 7;

  // Default buffer depth and reset value of the rail count.
  localparam int DEF_MAX_LEN = 64;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd3;

  // Width of the rail period 2*rows-2.
  localparam int PERIOD_W = ROWS_W + 1;

  // Commands from the controller to the address sequencer.
  typedef struct packed {
    logic start;  // load rail count and length, restart at position 0
    logic step;   // advance to the next position of the zigzag order
  } zrt_seq_cmd_t;

endpackage

>>> hw/rtl/zrt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module zrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/zrt_seq.sv
// Address sequencer that walks buffer positions in rail fence order.
module zrt_seq #(
  parameter int MAX_LEN = zrt_pkg::DEF_MAX_LEN,
  localparam int ADDR_W = $clog2(MAX_LEN),
  localparam int CNT_W = $clog2(MAX_LEN + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  zrt_pkg::zrt_seq_cmd_t     cmd,
  input  logic [zrt_pkg::ROWS_W-1:0] rows,
  input  logic [CNT_W-1:0]          len,
  output logic [ADDR_W-1:0]         pos
);

  import zrt_pkg::*;

  localparam int SUM_W = ((CNT_W > PERIOD_W) ? CNT_W : PERIOD_W) + 1;

  logic [CNT_W-1:0]    row;
  logic [CNT_W-1:0]    cur;
  logic                phase;
  logic                single;
  logic [PERIOD_W-1:0] period;
  logic [CNT_W-1:0]    len_r;

  logic [SUM_W-1:0] two_row;
  logic [SUM_W-1:0] down_step;
  logic [SUM_W-1:0] sel_step;
  logic [SUM_W-1:0] step_val;
  logic [SUM_W-1:0] nxt;
  logic             wrap;

  // Row i alternates steps of R-2i and 2i; a zero step means a full period.
  always_comb begin
    two_row   = SUM_W'(row) << 1;
    down_step = SUM_W'(period) - two_row;
    sel_step  = phase ? two_row : down_step;
    if (single) begin
      step_val = SUM_W'(1);
    end else if (sel_step == '0) begin
      step_val = SUM_W'(period);
    end else begin
      step_val = sel_step;
    end
    nxt  = SUM_W'(cur) + step_val;
    wrap = (nxt >= SUM_W'(len_r));
  end

  // Position, row and phase registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      cur    <= '0;
      phase  <= 1'b0;
      single <= 1'b1;
      period <= '0;
      len_r  <= '0;
    end else if (cmd.start) begin
      row    <= '0;
      cur    <= '0;
      phase  <= 1'b0;
      single <= (rows <= ROWS_W'(1));
      period <= {rows, 1'b0} - PERIOD_W'(2);
      len_r  <= len;
    end else if (cmd.step) begin
      if (wrap) begin
        row   <= row + CNT_W'(1);
        cur   <= row + CNT_W'(1);
        phase <= 1'b0;
      end else begin
        cur   <= nxt[CNT_W-1:0];
        phase <= ~phase;
      end
    end
  end

  assign pos = cur[ADDR_W-1:0];

endmodule

>>> hw/rtl/zigzag_rail_transposer.sv
// Top level of the zigzag rail transposer: load control, store and output stage.
//
// Usage: message bytes arrive on the s_axis channel, one per transaction, with
// s_axis_tlast on the final byte. Up to MAX_LEN bytes are kept in a RAM; later
// bytes are dropped and the run is marked truncated. When the final byte is
// taken, the stored bytes leave on the m_axis channel in rail fence order for
// num_rows rails (zero or one rail passes the message through), with
// m_axis_tlast on the last byte of the run and m_axis_tuser set on every byte
// of a truncated run.
// Timing: bytes are taken at one per cycle while loading. After the final byte
// is taken, each result is read from the RAM and then held in the output
// register; the output rate is set by the single RAM read kept in flight ahead
// of the output register. s_axis_tready is low while reads of a run are being
// issued, and returns high once the last read is out.
// A receiver stall holds the output register and pauses the read sequence.
// Reset clears the byte count and truncation flag and sets num_rows to 3; the RAM
// keeps no reset state and only written entries are ever read. The user must
// write the rail count (cfg_we / cfg_wdata) only while idle; it is not checked.
module zigzag_rail_transposer #(
  parameter int MAX_LEN = zrt_pkg::DEF_MAX_LEN
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration: num_rows.
  input  logic                        cfg_we,
  input  logic [zrt_pkg::ROWS_W-1:0]  cfg_wdata,
  // Input stream. tdata: in_char[7:0]. tlast: end_of_message.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [zrt_pkg::CHAR_W-1:0]  s_axis_tdata,
  input  logic                        s_axis_tlast,
  // Output stream. tdata: out_char[7:0]. tlast: run_last. tuser: truncated.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [zrt_pkg::CHAR_W-1:0]  m_axis_tdata,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser
);

  import zrt_pkg::*;

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state;
  logic [CNT_W-1:0]  count;
  logic              overflow;
  logic [ROWS_W-1:0] num_rows;
  logic [CNT_W-1:0]  run_len;
  logic              run_trunc;
  logic [CNT_W-1:0]  issued;
  logic              rd_pend;
  logic              rd_last;
  logic              rd_trunc;
  logic              out_valid;

  logic              in_acc;
  logic              room;
  logic [CNT_W-1:0]  count_next;
  logic              issue;
  logic              issue_last;
  logic [ADDR_W-1:0] seq_pos;
  logic [CHAR_W-1:0] ram_rdata;
  zrt_seq_cmd_t      seq_cmd;

  // Input handshake and store write decision.
  assign s_axis_tready = (state == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign room          = (count < CNT_W'(MAX_LEN));
  assign count_next    = count + CNT_W'(room);

  // One read in flight at a time, issued only when the output register frees.
  assign issue      = (state == ST_EMIT) && !rd_pend && (!out_valid || m_axis_tready);
  assign issue_last = ((issued + CNT_W'(1)) == run_len);

  assign seq_cmd.start = in_acc && s_axis_tlast;
  assign seq_cmd.step  = issue;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= ROWS_RESET;
    end else if (cfg_we) begin
      num_rows <= cfg_wdata;
    end
  end

  // Load and emit control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      overflow  <= 1'b0;
      run_len   <= '0;
      run_trunc <= 1'b0;
      issued    <= '0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (in_acc) begin
        if (s_axis_tlast) begin
          state     <= ST_EMIT;
          run_len   <= count_next;
          run_trunc <= overflow || !room;
          count     <= '0;
          overflow  <= 1'b0;
          issued    <= '0;
        end else begin
          count    <= count_next;
          overflow <= overflow || !room;
        end
      end else if (issue) begin
        issued <= issued + CNT_W'(1);
        if (issue_last) begin
          state <= ST_LOAD;
        end
      end
    end
  end

  // Tags that travel with the read in flight.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last  <= issue_last;
      rd_trunc <= run_trunc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      m_axis_tdata <= ram_rdata;
      m_axis_tlast <= rd_last;
      m_axis_tuser <= rd_trunc;
    end
  end

  assign m_axis_tvalid = out_valid;

  // Message store.
  zrt_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (in_acc && room),
    .waddr (count[ADDR_W-1:0]),
    .wdata (s_axis_tdata),
    .re    (issue),
    .raddr (seq_pos),
    .rdata (ram_rdata)
  );

  // Zigzag address sequencer.
  zrt_seq #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .cmd  (seq_cmd),
    .rows (num_rows),
    .len  (count_next),
    .pos  (seq_pos)
  );

  // Every read lands in the output register on the next cycle.
  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> out_valid)
    else $error("read data did not reach the output register");

  // Reads only touch positions written in the current run.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (CNT_W'(seq_pos) < run_len))
    else $error("read address beyond the stored message");

  // While emitting, fewer reads have been issued than bytes stored.
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (issued < run_len))
    else $error("read count overran the run length");

  // A new read never starts while the output register is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !issue)
    else $error("read issued into a stalled output register");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the zigzag rail transposer: random and directed messages.
`timescale 1ns / 100ps

module tb_top;
  import zrt_pkg::*;

  localparam int MSG_DEPTH   = DEF_MAX_LEN;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_GAP   = 12;
  localparam int CYCLE_LIMIT = 100000;

  // One message byte as it enters the block.
  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              eom;
  } msg_byte_t;

  // One transposed byte as it leaves the block.
  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
    logic              truncated;
  } rail_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [ROWS_W-1:0] cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [CHAR_W-1:0] s_axis_tdata = '0;  // in_char[7:0]
  logic              s_axis_tlast = 1'b0;  // end_of_message
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [CHAR_W-1:0] m_axis_tdata;  // out_char[7:0]
  logic              m_axis_tlast;  // run_last
  logic              m_axis_tuser;  // truncated

  // Stimulus and scoreboard state.
  msg_byte_t   send_q[$];
  rail_byte_t  rail_out_q[$];
  rail_byte_t  exp_b;
  msg_byte_t   next_b;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          fail_count = 0;
  int          cycle_cnt = 0;
  logic        hold_kick = 1'b0;
  int          hold_left = 0;

  // Mirror of the block's state used for prediction.
  logic [CHAR_W-1:0] msg_mem [MSG_DEPTH];
  int                msg_len = 0;
  logic              msg_overflow = 1'b0;
  logic [ROWS_W-1:0] rail_count = ROWS_RESET;

  zigzag_rail_transposer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Store one byte and, on the end of a message, queue the whole run in rail fence order.
  function automatic void absorb_msg_byte(input logic [CHAR_W-1:0] ch, input logic eom);
    int rails;
    int period;
    rail_byte_t run_q[$];
    rail_byte_t ob;
    if (msg_len < MSG_DEPTH) begin
      msg_mem[msg_len] = ch;
      msg_len++;
    end else begin
      msg_overflow = 1'b1;
    end
    if (!eom) return;
    rails = (rail_count == 0) ? 1 : int'(rail_count);
    ob.run_last = 1'b0;
    ob.truncated = msg_overflow;
    if (rails == 1) begin
      for (int j = 0; j < msg_len; j++) begin
        ob.out_char = msg_mem[j];
        run_q.push_back(ob);
      end
    end else begin
      period = 2 * rails - 2;
      // A position belongs to a rail when it sits on its down or up stroke.
      for (int row = 0; row < rails && row < msg_len; row++) begin
        for (int j = row; j < msg_len; j++) begin
          if (((j - row) % period == 0) || ((j + row) % period == 0)) begin
            ob.out_char = msg_mem[j];
            run_q.push_back(ob);
          end
        end
      end
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].run_last = 1'b1;
    foreach (run_q[i]) rail_out_q.push_back(run_q[i]);
    msg_len = 0;
    msg_overflow = 1'b0;
  endfunction

  // Input driver: offers queued bytes, idling at random, and predicts each accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) absorb_msg_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_b = send_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= next_b.in_char;
          s_axis_tlast <= next_b.eom;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here once kicked.
  always @(posedge clk) begin
    if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output monitor: compare each transaction with the oldest predicted byte.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rail_out_q.size() == 0) begin
        $error("out_char: no byte expected, got %02h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_b = rail_out_q.pop_front();
        if (m_axis_tdata !== exp_b.out_char) begin
          $error("out_char: expected %02h, got %02h", exp_b.out_char, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== exp_b.run_last) begin
          $error("run_last: expected %0b, got %0b", exp_b.run_last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== exp_b.truncated) begin
          $error("truncated: expected %0b, got %0b", exp_b.truncated, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_byte(input logic [CHAR_W-1:0] ch, input logic eom);
    msg_byte_t b;
    b.in_char = ch;
    b.eom = eom;
    send_q.push_back(b);
  endtask

  task automatic queue_rand_msg(input int len);
    for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  // Wait until all bytes are sent and all results seen, then let the block settle.
  task automatic drain();
    do @(negedge clk);
    while (send_q.size() != 0 || s_axis_tvalid || rail_out_q.size() != 0);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // Rail count write; only called while the block is idle.
  task automatic set_rails(input logic [ROWS_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rail_count = v;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
      default: begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
  endtask

  initial begin : stimulus
    int phase_bytes;
    int len;
    int pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes at the reset rail count, then the special rail counts.
    set_idling(0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h55, 1'b1);
    drain();
    set_rails(7'd0);
    queue_rand_msg(3);
    drain();
    set_rails(7'd127);
    queue_rand_msg(4);
    drain();
    set_rails(7'd2);
    queue_rand_msg(6);
    drain();
    set_rails(7'd1);
    queue_rand_msg(3);
    drain();

    // Random phases under rotating idling modes.
    for (int p = 0; p < 6; p++) begin
      set_idling(p % 4);
      if (p == 0) begin
        // Long message with many rails.
        set_rails(7'd64);
        queue_rand_msg(20);
      end else if (p == 1) begin
        // One byte too many: the final byte is dropped and the run is truncated.
        set_rails(7'd3);
        queue_rand_msg(MSG_DEPTH + 1);
      end else begin
        pick = $urandom_range(5);
        case (pick)
          0: set_rails(7'd0);
          1: set_rails(7'd127);
          2: set_rails(7'($urandom_range(127, 64)));
          default: set_rails(7'($urandom_range(10, 1)));
        endcase
        // The receiver holds off while messages keep coming, so the input backs up.
        if (p == 4) begin
          @(posedge clk);
          hold_kick <= 1'b1;
          @(posedge clk);
          hold_kick <= 1'b0;
        end
        // The hold-off phase queues several messages behind the stalled one.
        phase_bytes = 0;
        while (phase_bytes < ((p == 4) ? 20 : 4)) begin
          len = $urandom_range(12, 1);
          queue_rand_msg(len);
          phase_bytes += len;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
